// ===== design/prs_pkg.sv =====
// Shared types and constants for the primitive root search block.
// No dependencies; imported by every module of the block.
`default_nettype none
package prs_pkg;

    localparam int WIDTH       = 32;
    localparam int MAX_FACTORS = 10;
    localparam int CNT_W       = $clog2(MAX_FACTORS + 1);
    localparam int IDX_W       = $clog2(MAX_FACTORS);
    localparam int DIV_STEPS   = 2 * WIDTH;
    localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD_FAC2,
        OP_SHIFT_V,
        OP_D_INIT,
        OP_DIV_VD,
        OP_D_STEP,
        OP_ADD_FAC_D,
        OP_V_QUOT,
        OP_ADD_FAC_V,
        OP_K_INIT,
        OP_DIV_PHI_FAC,
        OP_EXP_INIT,
        OP_MUL_AB,
        OP_MUL_BB,
        OP_DIV_PROD,
        OP_ACC_REM,
        OP_B_REM_ESH,
        OP_K_STEP,
        OP_R_STEP,
        OP_SET_FOUND,
        OP_SET_NONE
    } dp_op_t;

    typedef struct packed {
        logic n_lt2;
        logic v_zero;
        logic v_even;
        logic v_gt2;
        logic d_gt_q;
        logic rem_zero;
        logic fac_full;
        logic r_gt_phi;
        logic k_eq_cnt;
        logic e_zero;
        logic e_odd;
        logic acc_one;
        logic div_done;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TWO,
        ST_SHIFT,
        ST_DLOOP,
        ST_DIV_W,
        ST_DTEST,
        ST_DREP,
        ST_DREP_W,
        ST_TAIL,
        ST_RLOOP,
        ST_KLOOP,
        ST_PHI_W,
        ST_EXP,
        ST_MA_DIV,
        ST_MA_W,
        ST_MULB,
        ST_MB_DIV,
        ST_MB_W,
        ST_EVAL,
        ST_RESULT
    } state_t;

endpackage
`default_nettype wire

// ===== design/prs_divider.sv =====
// Restoring divider, one quotient bit per cycle (2*WIDTH by WIDTH bits).
// Depends on prs_pkg.
`default_nettype none
module prs_divider
    import prs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [2*WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0]   divisor,
    output logic      [2*WIDTH-1:0] quot,
    output logic      [WIDTH-1:0]   rem,
    output logic                    done
);

    logic [2*WIDTH-1:0] quot_reg;
    logic [WIDTH-1:0]   rem_reg;
    logic [WIDTH-1:0]   dvs_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [WIDTH:0]     trial;
    logic               ge;
    logic [WIDTH:0]     diff;

    assign trial = {rem_reg, quot_reg[2*WIDTH-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[2*WIDTH-2:0], ge};
            rem_reg  <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ===== design/prs_datapath.sv =====
// Datapath: factor table, search registers, multiplier and shared divider.
// Depends on prs_pkg and prs_divider.
`default_nettype none
module prs_datapath
    import prs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dp_op_t           op,
    input  wire logic [WIDTH-1:0] modulus,
    output dp_status_t            status,
    output logic      [WIDTH-1:0] root,
    output logic                  found
);

    logic [WIDTH-1:0]   n_reg, phi_reg, v_reg, d_reg, r_reg, acc_reg, b_reg;
    logic [WIDTH-1:0]   e_reg;
    logic [WIDTH-1:0]   fac_reg [MAX_FACTORS];
    logic [CNT_W-1:0]   cnt_reg, k_reg;
    logic [2*WIDTH-1:0] prod_reg;
    logic [WIDTH-1:0]   root_reg;
    logic               found_reg;

    logic               div_start;
    logic [2*WIDTH-1:0] div_dividend;
    logic [WIDTH-1:0]   div_divisor;
    logic [2*WIDTH-1:0] div_quot;
    logic [WIDTH-1:0]   div_rem;
    logic               div_done;
    logic [WIDTH-1:0]   fac_k;

    assign fac_k = fac_reg[k_reg[IDX_W-1:0]];

    always_comb begin
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = n_reg;
        case (op)
            OP_DIV_VD: begin
                div_start    = 1'b1;
                div_dividend = {{WIDTH{1'b0}}, v_reg};
                div_divisor  = d_reg;
            end
            OP_DIV_PHI_FAC: begin
                div_start    = 1'b1;
                div_dividend = {{WIDTH{1'b0}}, phi_reg};
                div_divisor  = fac_k;
            end
            OP_DIV_PROD: begin
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    prs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                n_reg   <= modulus;
                phi_reg <= modulus - WIDTH'(1);
                v_reg   <= modulus - WIDTH'(1);
                cnt_reg <= '0;
                r_reg   <= WIDTH'(2);
            end
            OP_ADD_FAC2: begin
                fac_reg[cnt_reg[IDX_W-1:0]] <= WIDTH'(2);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_SHIFT_V:  v_reg <= v_reg >> 1;
            OP_D_INIT:   d_reg <= WIDTH'(3);
            OP_D_STEP:   d_reg <= d_reg + WIDTH'(2);
            OP_ADD_FAC_D: begin
                if (cnt_reg != CNT_W'(MAX_FACTORS)) begin
                    fac_reg[cnt_reg[IDX_W-1:0]] <= d_reg;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                v_reg <= div_quot[WIDTH-1:0];
            end
            OP_V_QUOT:   v_reg <= div_quot[WIDTH-1:0];
            OP_ADD_FAC_V: begin
                fac_reg[cnt_reg[IDX_W-1:0]] <= v_reg;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_K_INIT:   k_reg <= '0;
            OP_EXP_INIT: begin
                e_reg   <= div_quot[WIDTH-1:0];
                acc_reg <= WIDTH'(1);
                b_reg   <= r_reg;
            end
            OP_MUL_AB:   prod_reg <= acc_reg * b_reg;
            OP_MUL_BB:   prod_reg <= b_reg * b_reg;
            OP_ACC_REM:  acc_reg <= div_rem;
            OP_B_REM_ESH: begin
                b_reg <= div_rem;
                e_reg <= e_reg >> 1;
            end
            OP_K_STEP:   k_reg <= k_reg + CNT_W'(1);
            OP_R_STEP:   r_reg <= r_reg + WIDTH'(1);
            OP_SET_FOUND: begin
                root_reg  <= r_reg;
                found_reg <= 1'b1;
            end
            OP_SET_NONE: begin
                root_reg  <= '0;
                found_reg <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.n_lt2    = (n_reg < WIDTH'(2));
        status.v_zero   = (v_reg == '0);
        status.v_even   = ~v_reg[0];
        status.v_gt2    = (v_reg > WIDTH'(2));
        status.d_gt_q   = ({{WIDTH{1'b0}}, d_reg} > div_quot);
        status.rem_zero = (div_rem == '0);
        status.fac_full = (cnt_reg == CNT_W'(MAX_FACTORS));
        status.r_gt_phi = (r_reg > phi_reg);
        status.k_eq_cnt = (k_reg == cnt_reg);
        status.e_zero   = (e_reg == '0);
        status.e_odd    = e_reg[0];
        status.acc_one  = (acc_reg == WIDTH'(1));
        status.div_done = div_done;
    end

    assign root  = root_reg;
    assign found = found_reg;

endmodule
`default_nettype wire

// ===== design/prs_ctrl.sv =====
// Controller state machine sequencing factoring and candidate testing.
// Depends on prs_pkg.
`default_nettype none
module prs_ctrl
    import prs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_op_t          op
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = status.n_lt2 ? ST_RESULT : ST_TWO;
            ST_TWO:    state_next = ST_SHIFT;
            ST_SHIFT:  if (status.v_zero || !status.v_even) state_next = ST_DLOOP;
            ST_DLOOP:  state_next = status.v_zero ? ST_TAIL : ST_DIV_W;
            ST_DIV_W:  if (status.div_done) state_next = ST_DTEST;
            ST_DTEST: begin
                if (status.d_gt_q)        state_next = ST_TAIL;
                else if (!status.rem_zero) state_next = ST_DLOOP;
                else                       state_next = ST_DREP;
            end
            ST_DREP:   state_next = ST_DREP_W;
            ST_DREP_W: begin
                if (status.div_done) state_next = status.rem_zero ? ST_DREP : ST_DLOOP;
            end
            ST_TAIL:   state_next = ST_RLOOP;
            ST_RLOOP:  state_next = status.r_gt_phi ? ST_RESULT : ST_KLOOP;
            ST_KLOOP:  state_next = status.k_eq_cnt ? ST_RESULT : ST_PHI_W;
            ST_PHI_W:  if (status.div_done) state_next = ST_EXP;
            ST_EXP: begin
                if (status.e_zero)     state_next = ST_EVAL;
                else if (status.e_odd) state_next = ST_MA_DIV;
                else                   state_next = ST_MB_DIV;
            end
            ST_MA_DIV: state_next = ST_MA_W;
            ST_MA_W:   if (status.div_done) state_next = ST_MULB;
            ST_MULB:   state_next = ST_MB_DIV;
            ST_MB_DIV: state_next = ST_MB_W;
            ST_MB_W:   if (status.div_done) state_next = ST_EXP;
            ST_EVAL:   state_next = status.acc_one ? ST_RLOOP : ST_KLOOP;
            ST_RESULT: if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        op        = OP_NONE;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) op = OP_LOAD;
            end
            ST_CHECK:  if (status.n_lt2) op = OP_SET_NONE;
            ST_TWO:    if (!status.v_zero && status.v_even) op = OP_ADD_FAC2;
            ST_SHIFT:  op = (!status.v_zero && status.v_even) ? OP_SHIFT_V : OP_D_INIT;
            ST_DLOOP:  if (!status.v_zero) op = OP_DIV_VD;
            ST_DTEST: begin
                if (!status.d_gt_q) op = status.rem_zero ? OP_ADD_FAC_D : OP_D_STEP;
            end
            ST_DREP:   op = OP_DIV_VD;
            ST_DREP_W: begin
                if (status.div_done) op = status.rem_zero ? OP_V_QUOT : OP_D_STEP;
            end
            ST_TAIL:   if (status.v_gt2 && !status.fac_full) op = OP_ADD_FAC_V;
            ST_RLOOP:  op = status.r_gt_phi ? OP_SET_NONE : OP_K_INIT;
            ST_KLOOP:  op = status.k_eq_cnt ? OP_SET_FOUND : OP_DIV_PHI_FAC;
            ST_PHI_W:  if (status.div_done) op = OP_EXP_INIT;
            ST_EXP: begin
                if (!status.e_zero) op = status.e_odd ? OP_MUL_AB : OP_MUL_BB;
            end
            ST_MA_DIV: op = OP_DIV_PROD;
            ST_MA_W:   if (status.div_done) op = OP_ACC_REM;
            ST_MULB:   op = OP_MUL_BB;
            ST_MB_DIV: op = OP_DIV_PROD;
            ST_MB_W:   if (status.div_done) op = OP_B_REM_ESH;
            ST_EVAL:   op = status.acc_one ? OP_R_STEP : OP_K_STEP;
            ST_RESULT: out_valid = 1'b1;
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/primitive_root_search_unit.sv =====
// Primitive root search: smallest primitive root modulo n, one request at a time.
// Latency is data dependent: every division runs on the single
// shared restoring divider, which sets the figure (trial division plus one
// square-and-multiply per factor per candidate, one or two divides per exponent bit).
// Throughput: one request per search; s_tready is high only while idle.
// Reset: aresetn synchronous, active low; returns to idle with no result pending.
`default_nettype none
module primitive_root_search_unit
    import prs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // request channel
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [WIDTH-1:0] s_tdata,   // [31:0] modulus
    // result channel
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [WIDTH-1:0] m_tdata,   // [31:0] root
    output logic                  m_tuser    // [0] found
);

    dp_op_t     op;
    dp_status_t status;

    // sequencer: factoring of n-1, then candidate loop over r
    prs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .op        (op)
    );

    // registers, multiplier and divider; result held until taken
    prs_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .modulus (s_tdata),
        .status  (status),
        .root    (m_tdata),
        .found   (m_tuser)
    );

    // a pending result blocks new requests
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request accepted while a result is pending");

    // no root means root reads zero; a found root is at least two
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero root without found");

    a_root_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata >= WIDTH'(2)))
        else $error("found root below two");

    // in the cycle after acceptance the search is busy: not ready and no result shown
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("idle directly after accepting a request");

endmodule
`default_nettype wire
